[rtl/bcf_pkg.sv]
// ----------------------------------------------------------------------------
// bcf_pkg: shared types and constants for the bitvector constant folder
// Item layouts, operation and status codes, and the mask and sign helpers.
// ----------------------------------------------------------------------------
package bcf_pkg;

  localparam int VAL_W = 64;
  localparam int WID_W = 7;
  localparam int OFF_W = 6;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_MUL   = 5'd2;
  localparam logic [4:0] OP_AND   = 5'd3;
  localparam logic [4:0] OP_OR    = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_SHL   = 5'd6;
  localparam logic [4:0] OP_LSHR  = 5'd7;
  localparam logic [4:0] OP_ASHR  = 5'd8;
  localparam logic [4:0] OP_ROL   = 5'd9;
  localparam logic [4:0] OP_ROR   = 5'd10;
  localparam logic [4:0] OP_UDIV  = 5'd11;
  localparam logic [4:0] OP_UREM  = 5'd12;
  localparam logic [4:0] OP_SDIV  = 5'd13;
  localparam logic [4:0] OP_SREM  = 5'd14;
  localparam logic [4:0] OP_EQ    = 5'd15;
  localparam logic [4:0] OP_NE    = 5'd16;
  localparam logic [4:0] OP_ULT   = 5'd17;
  localparam logic [4:0] OP_ULE   = 5'd18;
  localparam logic [4:0] OP_SLT   = 5'd19;
  localparam logic [4:0] OP_SLE   = 5'd20;
  localparam logic [4:0] OP_TRUNC = 5'd21;
  localparam logic [4:0] OP_ZEXT  = 5'd22;
  localparam logic [4:0] OP_SEXT  = 5'd23;
  localparam logic [4:0] OP_EXTR  = 5'd24;
  localparam logic [4:0] OP_PASS  = 5'd25;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFOLD = 2'd1;
  localparam logic [1:0] ST_BADW   = 2'd2;

  typedef struct packed {
    logic [4:0]       mode;
    logic [WID_W-1:0] operand_width;
    logic [WID_W-1:0] result_width;
    logic [VAL_W-1:0] left_value;
    logic [VAL_W-1:0] right_value;
    logic [OFF_W-1:0] bit_offset;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic [1:0]       status;
  } out_item_t;

  // Per-item data that rides along the divider chain
  typedef struct packed {
    logic [4:0]       mode;
    logic [WID_W-1:0] ow;
    logic [WID_W-1:0] rw;
    logic [1:0]       status;
    logic [VAL_W-1:0] simple;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] mul_ll;
    logic [31:0]      mul_lh;
    logic [31:0]      mul_hl;
    logic             an;
    logic             bn;
  } side_t;

  function automatic logic [VAL_W-1:0] width_mask(input logic [WID_W-1:0] w);
    logic [VAL_W-1:0] m;
    if (w >= WID_W'(VAL_W)) m = '1;
    else m = (VAL_W'(1) << w) - VAL_W'(1);
    return m;
  endfunction

  function automatic logic [VAL_W-1:0] sign_fill(input logic [VAL_W-1:0] v,
                                                 input logic [WID_W-1:0] w);
    logic [VAL_W-1:0] m;
    logic [VAL_W-1:0] r;
    m = width_mask(w);
    r = v & m;
    if (w >= WID_W'(1) && w < WID_W'(VAL_W) && r[OFF_W'(w - WID_W'(1))]) r = r | ~m;
    return r;
  endfunction

endpackage

[rtl/bitvector_constant_fold_alu.sv]
// ----------------------------------------------------------------------------
// bitvector_constant_fold_alu: variable-width bitvector constant folder
// Folds one operation on two constants of 1 to MAX_WIDTH bits per item.
// ----------------------------------------------------------------------------
// Usage:
//   Present an item on in_data with in_valid; it is taken on an edge where
//   in_ready is also high. Each item yields exactly one result item on
//   out_data (value masked to result width, plus status), in input order.
//   Each item passes through one decode register, MAX_WIDTH divider
//   cells (one quotient bit each, the longest path an item walks), and the
//   output register. Every operation walks the same chain, so order holds.
//   Throughput is one item per cycle while not stalled; the chain keeps
//   MAX_WIDTH + 2 items in flight. Rotates use the chain for amount mod width.
//   When the receiver stalls (out_valid high, out_ready low) the whole chain
//   holds and in_ready drops; it advances again in the cycle out_ready
//   rises. Reset clears all valid bits; data registers carry no reset.
//   Widths invalid for the operation give status 2, divide by zero and the
//   full-width signed overflow give status 1, both with a zero value.
// ----------------------------------------------------------------------------
module bitvector_constant_fold_alu #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bcf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bcf_pkg::out_item_t  out_data
);

  logic adv;

  // Front decode
  bcf_pkg::side_t         f_side;
  logic [MAX_WIDTH-1:0]   f_dvd;
  logic [MAX_WIDTH-1:0]   f_dsr;

  // Chain taps: index 0 is the decode register, index k the output of cell k-1
  logic                   c_valid [0:MAX_WIDTH];
  logic [MAX_WIDTH-1:0]   c_dvd   [0:MAX_WIDTH];
  logic [MAX_WIDTH-1:0]   c_dsr   [0:MAX_WIDTH];
  logic [MAX_WIDTH-1:0]   c_rem   [0:MAX_WIDTH];
  logic [MAX_WIDTH-1:0]   c_quo   [0:MAX_WIDTH];
  bcf_pkg::side_t         c_side  [0:MAX_WIDTH];

  logic                   s0_valid_r;
  logic [MAX_WIDTH-1:0]   s0_dvd_r;
  logic [MAX_WIDTH-1:0]   s0_dsr_r;
  bcf_pkg::side_t         s0_side_r;

  logic                   out_valid_r;
  bcf_pkg::out_item_t     out_data_r;
  bcf_pkg::out_item_t     out_data_nxt;

  // Advance everything whenever the output register is free or being taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  bcf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .item (in_data),
    .side (f_side),
    .dvd  (f_dvd),
    .dsr  (f_dsr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dvd_r  <= f_dvd;
      s0_dsr_r  <= f_dsr;
      s0_side_r <= f_side;
    end
  end

  assign c_valid[0] = s0_valid_r;
  assign c_dvd[0]   = s0_dvd_r;
  assign c_dsr[0]   = s0_dsr_r;
  assign c_rem[0]   = '0;
  assign c_quo[0]   = '0;
  assign c_side[0]  = s0_side_r;

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    bcf_div_cell #(.WIDTH(MAX_WIDTH)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (c_valid[k]),
      .dvd_i   (c_dvd[k]),
      .dsr_i   (c_dsr[k]),
      .rem_i   (c_rem[k]),
      .quo_i   (c_quo[k]),
      .side_i  (c_side[k]),
      .valid_o (c_valid[k+1]),
      .dvd_o   (c_dvd[k+1]),
      .dsr_o   (c_dsr[k+1]),
      .rem_o   (c_rem[k+1]),
      .quo_o   (c_quo[k+1]),
      .side_o  (c_side[k+1])
    );
  end

  // Final select at the end of the chain
  bcf_pkg::side_t   t_side;
  logic [63:0]      t_quo;
  logic [63:0]      t_rem;
  logic [5:0]       t_amt;
  logic [6:0]       t_back;
  logic [63:0]      t_val;
  logic [31:0]      t_cross;

  assign t_side  = c_side[MAX_WIDTH];
  assign t_quo   = 64'(c_quo[MAX_WIDTH]);
  assign t_rem   = 64'(c_rem[MAX_WIDTH]);
  assign t_amt   = t_rem[5:0];
  assign t_back  = t_side.ow - {1'b0, t_amt};
  assign t_cross = t_side.mul_lh + t_side.mul_hl;

  always_comb begin
    unique case (t_side.mode)
      bcf_pkg::OP_MUL:  t_val = t_side.mul_ll + {t_cross, 32'd0};
      bcf_pkg::OP_ROL:  t_val = (t_amt == 6'd0) ? t_side.a :
                                ((t_side.a << t_amt) | (t_side.a >> t_back));
      bcf_pkg::OP_ROR:  t_val = (t_amt == 6'd0) ? t_side.a :
                                ((t_side.a >> t_amt) | (t_side.a << t_back));
      bcf_pkg::OP_UDIV: t_val = t_quo;
      bcf_pkg::OP_UREM: t_val = t_rem;
      bcf_pkg::OP_SDIV: t_val = (t_side.an ^ t_side.bn) ? (64'd0 - t_quo) : t_quo;
      bcf_pkg::OP_SREM: t_val = t_side.an ? (64'd0 - t_rem) : t_rem;
      default:          t_val = t_side.simple;
    endcase
  end

  always_comb begin
    out_data_nxt.status       = t_side.status;
    out_data_nxt.result_value = (t_side.status == bcf_pkg::ST_OK) ?
                                (t_val & bcf_pkg::width_mask(t_side.rw)) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid[MAX_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/bcf_front.sv]
// ----------------------------------------------------------------------------
// bcf_front: operand decode for the constant folder
// Checks widths, masks operands, folds the simple operations, forms the
// partial products and sets up dividend and divisor for the divider chain.
// ----------------------------------------------------------------------------
module bcf_front #(
  parameter int MAX_WIDTH = 64
) (
  input  bcf_pkg::in_item_t       item,
  output bcf_pkg::side_t          side,
  output logic [MAX_WIDTH-1:0]    dvd,
  output logic [MAX_WIDTH-1:0]    dsr
);

  localparam logic [bcf_pkg::WID_W-1:0] MAXW = bcf_pkg::WID_W'(MAX_WIDTH);

  logic [bcf_pkg::WID_W-1:0] ow;
  logic [bcf_pkg::WID_W-1:0] rw;
  logic [bcf_pkg::WID_W-1:0] off;
  logic                      fit;
  logic [bcf_pkg::VAL_W-1:0] omask;
  logic [bcf_pkg::VAL_W-1:0] a;
  logic [bcf_pkg::VAL_W-1:0] b;
  logic [bcf_pkg::VAL_W-1:0] sa;
  logic [bcf_pkg::VAL_W-1:0] sb;
  logic [bcf_pkg::VAL_W-1:0] abs_a;
  logic [bcf_pkg::VAL_W-1:0] abs_b;
  logic                      big;
  logic [bcf_pkg::VAL_W-1:0] v;
  logic [bcf_pkg::VAL_W-1:0] dvd64;
  logic [bcf_pkg::VAL_W-1:0] dsr64;
  logic [1:0]                st;
  logic [31:0]               p_lh;
  logic [31:0]               p_hl;

  assign ow  = item.operand_width;
  assign rw  = item.result_width;
  assign off = {1'b0, item.bit_offset};

  always_comb begin
    if (ow < 7'd1 || ow > MAXW || rw < 7'd1 || rw > MAXW) begin
      fit = 1'b0;
    end else if (item.mode <= bcf_pkg::OP_SREM) begin
      fit = (rw == ow);
    end else if (item.mode <= bcf_pkg::OP_SLE) begin
      fit = (rw == 7'd1);
    end else begin
      unique case (item.mode)
        bcf_pkg::OP_TRUNC: fit = (rw < ow);
        bcf_pkg::OP_ZEXT,
        bcf_pkg::OP_SEXT:  fit = (rw > ow);
        bcf_pkg::OP_EXTR:  fit = (off < ow) && (rw <= ow - off);
        bcf_pkg::OP_PASS:  fit = (rw == ow);
        default:           fit = 1'b0;
      endcase
    end
  end

  assign omask = bcf_pkg::width_mask(ow);
  assign a     = item.left_value & omask;
  assign b     = item.right_value & omask;
  assign sa    = bcf_pkg::sign_fill(a, ow);
  assign sb    = bcf_pkg::sign_fill(b, ow);
  assign abs_a = sa[63] ? (64'd0 - sa) : sa;
  assign abs_b = sb[63] ? (64'd0 - sb) : sb;
  assign big   = (b >= {57'd0, ow});

  always_comb begin
    v = '0;
    unique case (item.mode)
      bcf_pkg::OP_ADD:   v = a + b;
      bcf_pkg::OP_SUB:   v = a - b;
      bcf_pkg::OP_AND:   v = a & b;
      bcf_pkg::OP_OR:    v = a | b;
      bcf_pkg::OP_XOR:   v = a ^ b;
      bcf_pkg::OP_SHL:   v = big ? 64'd0 : (a << b[5:0]);
      bcf_pkg::OP_LSHR:  v = big ? 64'd0 : (a >> b[5:0]);
      bcf_pkg::OP_ASHR:  v = big ? {64{sa[63]}} : 64'($signed(sa) >>> b[5:0]);
      bcf_pkg::OP_EQ:    v = {63'd0, a == b};
      bcf_pkg::OP_NE:    v = {63'd0, a != b};
      bcf_pkg::OP_ULT:   v = {63'd0, a < b};
      bcf_pkg::OP_ULE:   v = {63'd0, a <= b};
      bcf_pkg::OP_SLT:   v = {63'd0, $signed(sa) < $signed(sb)};
      bcf_pkg::OP_SLE:   v = {63'd0, $signed(sa) <= $signed(sb)};
      bcf_pkg::OP_TRUNC,
      bcf_pkg::OP_ZEXT,
      bcf_pkg::OP_PASS:  v = a;
      bcf_pkg::OP_SEXT:  v = sa;
      bcf_pkg::OP_EXTR:  v = a >> item.bit_offset;
      default:           v = '0;
    endcase
  end

  // Divider operands: rotates reuse the chain to reduce the amount mod width
  always_comb begin
    unique case (item.mode)
      bcf_pkg::OP_SDIV,
      bcf_pkg::OP_SREM: begin
        dvd64 = abs_a;
        dsr64 = abs_b;
      end
      bcf_pkg::OP_ROL,
      bcf_pkg::OP_ROR: begin
        dvd64 = b;
        dsr64 = {57'd0, ow};
      end
      default: begin
        dvd64 = a;
        dsr64 = b;
      end
    endcase
  end

  always_comb begin
    st = bcf_pkg::ST_OK;
    if (!fit) begin
      st = bcf_pkg::ST_BADW;
    end else if ((item.mode == bcf_pkg::OP_UDIV || item.mode == bcf_pkg::OP_UREM ||
                  item.mode == bcf_pkg::OP_SDIV || item.mode == bcf_pkg::OP_SREM) &&
                 b == 64'd0) begin
      st = bcf_pkg::ST_NOFOLD;
    end else if ((item.mode == bcf_pkg::OP_SDIV || item.mode == bcf_pkg::OP_SREM) &&
                 ow == 7'd64 && sa == {1'b1, 63'd0} && sb == '1) begin
      st = bcf_pkg::ST_NOFOLD;
    end
  end

  // Only the low halves of the cross products reach the 64-bit result
  assign p_lh = a[31:0] * b[63:32];
  assign p_hl = a[63:32] * b[31:0];

  always_comb begin
    side        = '0;
    side.mode   = item.mode;
    side.ow     = ow;
    side.rw     = rw;
    side.status = st;
    side.simple = v;
    side.a      = a;
    side.mul_ll = a[31:0] * b[31:0];
    side.mul_lh = p_lh;
    side.mul_hl = p_hl;
    side.an     = sa[63];
    side.bn     = sb[63];
  end

  assign dvd = dvd64[MAX_WIDTH-1:0];
  assign dsr = dsr64[MAX_WIDTH-1:0];

endmodule

[rtl/bcf_div_cell.sv]
// ----------------------------------------------------------------------------
// bcf_div_cell: one restoring-division step of the divider chain
// Shifts in one dividend bit, subtracts the divisor when it fits and hands
// remainder, quotient and the item's side data to the next cell.
// ----------------------------------------------------------------------------
module bcf_div_cell #(
  parameter int WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                valid_i,
  input  logic [WIDTH-1:0]    dvd_i,
  input  logic [WIDTH-1:0]    dsr_i,
  input  logic [WIDTH-1:0]    rem_i,
  input  logic [WIDTH-1:0]    quo_i,
  input  bcf_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [WIDTH-1:0]    dvd_o,
  output logic [WIDTH-1:0]    dsr_o,
  output logic [WIDTH-1:0]    rem_o,
  output logic [WIDTH-1:0]    quo_o,
  output bcf_pkg::side_t      side_o
);

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic             valid_r;
  logic [WIDTH-1:0] dvd_r;
  logic [WIDTH-1:0] dsr_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] quo_r;
  bcf_pkg::side_t   side_r;

  assign trial = {rem_i, dvd_i[WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_i};
  assign ge    = (trial >= {1'b0, dsr_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_r  <= {dvd_i[WIDTH-2:0], 1'b0};
      dsr_r  <= dsr_i;
      rem_r  <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_r  <= {quo_i[WIDTH-2:0], ge};
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign dvd_o   = dvd_r;
  assign dsr_o   = dsr_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;
  assign side_o  = side_r;

endmodule
